// ----- src/closest_point_on_segment_core_macros.svh -----
// Assertion helpers shared by the closest point core.
`ifndef CLOSEST_POINT_ON_SEGMENT_CORE_MACROS_SVH
`define CLOSEST_POINT_ON_SEGMENT_CORE_MACROS_SVH

// Concurrent check on clk_i, off while in reset.
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form of the above.
`define CPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/cps_pkg.sv -----
// ----------------------------------------------------------------------------
// cps_pkg
// Types and widths shared by the closest point on segment pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned MagW      = 32;
  localparam int unsigned ProdW     = 2 * MagW;
  localparam int unsigned DenW      = ProdW + 1;
  localparam int unsigned NumW      = ProdW + 2;
  localparam int unsigned LoW       = 32;
  localparam int unsigned HiW       = DenW - LoW;
  localparam int unsigned N2W       = MagW + DenW + 2;
  localparam int unsigned D2W       = DenW + 1;
  localparam int unsigned QW        = 32;
  localparam int unsigned RemW      = N2W - QW;
  localparam int unsigned DivStages = QW;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] closest_x;
    logic signed [CoordW-1:0] closest_y;
  } out_t;

  typedef struct packed {
    logic              zero;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic              sgnx;
    logic              sgny;
    logic [MagW-1:0]   mx;
    logic [MagW-1:0]   my;
    logic [DenW-1:0]   den;
    logic [DenW-1:0]   numc;
  } front_t;

  typedef struct packed {
    logic              zero;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic              sgnx;
    logic              sgny;
    logic [N2W-1:0]    n2x;
    logic [N2W-1:0]    n2y;
    logic [D2W-1:0]    d2;
  } scale_t;

  typedef struct packed {
    logic              zero;
    logic [CoordW-1:0] sx;
    logic [CoordW-1:0] sy;
    logic              sgnx;
    logic              sgny;
    logic [D2W-1:0]    d2;
    logic [RemW-1:0]   remx;
    logic [RemW-1:0]   remy;
    logic [QW-1:0]     lowx;
    logic [QW-1:0]     lowy;
    logic [QW-1:0]     qx;
    logic [QW-1:0]     qy;
  } div_t;

endpackage

// ----- src/cps_front.sv -----
// ----------------------------------------------------------------------------
// cps_front
// Differences, squared length, dot product and clamp, over four stages.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_macros.svh"

module cps_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cps_pkg::in_t    data_i,
  output logic            valid_o,
  output cps_pkg::front_t data_o
);

  localparam int unsigned CW = cps_pkg::CoordW;
  localparam int unsigned MW = cps_pkg::MagW;
  localparam int unsigned PW = cps_pkg::ProdW;
  localparam int unsigned DW = cps_pkg::DenW;
  localparam int unsigned NW = cps_pkg::NumW;

  logic [3:0] valid_q;

  // stage 1
  logic [CW-1:0] s1_sx_q, s1_sy_q;
  logic          s1_ndx_q, s1_ndy_q, s1_ntx_q, s1_nty_q;
  logic [MW-1:0] s1_mdx_q, s1_mdy_q, s1_mtx_q, s1_mty_q;
  // stage 2
  logic [CW-1:0] s2_sx_q, s2_sy_q;
  logic          s2_ndx_q, s2_ndy_q, s2_npx_q, s2_npy_q;
  logic [MW-1:0] s2_mdx_q, s2_mdy_q;
  logic [PW-1:0] s2_pdx_q, s2_pdy_q, s2_ptx_q, s2_pty_q;
  // stage 3
  logic [CW-1:0] s3_sx_q, s3_sy_q;
  logic          s3_ndx_q, s3_ndy_q;
  logic [MW-1:0] s3_mdx_q, s3_mdy_q;
  logic [DW-1:0] s3_den_q;
  logic [NW-1:0] s3_num_q;
  // stage 4
  cps_pkg::front_t s4_q;

  logic [CW:0]   dx_d, dy_d, tx_d, ty_d;
  logic [CW:0]   adx_d, ady_d, atx_d, aty_d;
  logic [NW-1:0] termx_d, termy_d;
  logic [DW-1:0] numc_d;

  always_comb begin
    dx_d  = {data_i.end_x[CW-1], data_i.end_x} - {data_i.start_x[CW-1], data_i.start_x};
    dy_d  = {data_i.end_y[CW-1], data_i.end_y} - {data_i.start_y[CW-1], data_i.start_y};
    tx_d  = {data_i.point_x[CW-1], data_i.point_x} - {data_i.start_x[CW-1], data_i.start_x};
    ty_d  = {data_i.point_y[CW-1], data_i.point_y} - {data_i.start_y[CW-1], data_i.start_y};
    adx_d = dx_d[CW] ? -dx_d : dx_d;
    ady_d = dy_d[CW] ? -dy_d : dy_d;
    atx_d = tx_d[CW] ? -tx_d : tx_d;
    aty_d = ty_d[CW] ? -ty_d : ty_d;
    termx_d = s2_npx_q ? -{2'b00, s2_ptx_q} : {2'b00, s2_ptx_q};
    termy_d = s2_npy_q ? -{2'b00, s2_pty_q} : {2'b00, s2_pty_q};
    // clamp the projection into [0, den]
    if (s3_num_q[NW-1]) begin
      numc_d = '0;
    end else if (s3_num_q[DW-1:0] > s3_den_q) begin
      numc_d = s3_den_q;
    end else begin
      numc_d = s3_num_q[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sx_q  <= data_i.start_x;
      s1_sy_q  <= data_i.start_y;
      s1_ndx_q <= dx_d[CW];
      s1_ndy_q <= dy_d[CW];
      s1_ntx_q <= tx_d[CW];
      s1_nty_q <= ty_d[CW];
      s1_mdx_q <= adx_d[MW-1:0];
      s1_mdy_q <= ady_d[MW-1:0];
      s1_mtx_q <= atx_d[MW-1:0];
      s1_mty_q <= aty_d[MW-1:0];

      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_ndx_q <= s1_ndx_q;
      s2_ndy_q <= s1_ndy_q;
      s2_npx_q <= s1_ntx_q ^ s1_ndx_q;
      s2_npy_q <= s1_nty_q ^ s1_ndy_q;
      s2_mdx_q <= s1_mdx_q;
      s2_mdy_q <= s1_mdy_q;
      s2_pdx_q <= s1_mdx_q * s1_mdx_q;
      s2_pdy_q <= s1_mdy_q * s1_mdy_q;
      s2_ptx_q <= s1_mtx_q * s1_mdx_q;
      s2_pty_q <= s1_mty_q * s1_mdy_q;

      s3_sx_q  <= s2_sx_q;
      s3_sy_q  <= s2_sy_q;
      s3_ndx_q <= s2_ndx_q;
      s3_ndy_q <= s2_ndy_q;
      s3_mdx_q <= s2_mdx_q;
      s3_mdy_q <= s2_mdy_q;
      s3_den_q <= {1'b0, s2_pdx_q} + {1'b0, s2_pdy_q};
      s3_num_q <= termx_d + termy_d;

      s4_q.zero <= (s3_den_q == '0);
      s4_q.sx   <= s3_sx_q;
      s4_q.sy   <= s3_sy_q;
      s4_q.sgnx <= s3_ndx_q;
      s4_q.sgny <= s3_ndy_q;
      s4_q.mx   <= s3_mdx_q;
      s4_q.my   <= s3_mdy_q;
      s4_q.den  <= s3_den_q;
      s4_q.numc <= numc_d;
    end
  end

  assign valid_o = valid_q[3];
  assign data_o  = s4_q;

  `CPS_ASSERT_IMP(a_clamp_bound, valid_q[3], s4_q.numc <= s4_q.den, "projection not clamped")

endmodule

// ----- src/cps_scale.sv -----
// ----------------------------------------------------------------------------
// cps_scale
// Scale the clamped projection by each axis length, split over two stages.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_macros.svh"

module cps_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cps_pkg::front_t data_i,
  output logic            valid_o,
  output cps_pkg::scale_t data_o
);

  localparam int unsigned MW = cps_pkg::MagW;
  localparam int unsigned LW = cps_pkg::LoW;
  localparam int unsigned HW = cps_pkg::HiW;
  localparam int unsigned DW = cps_pkg::DenW;
  localparam int unsigned NW = cps_pkg::N2W;

  logic [1:0] valid_q;

  logic                      p_zero_q, p_sgnx_q, p_sgny_q;
  logic [cps_pkg::CoordW-1:0] p_sx_q, p_sy_q;
  logic [DW-1:0]             p_den_q;
  logic [MW+LW-1:0]          p_lox_q, p_loy_q;
  logic [MW+HW-1:0]          p_hix_q, p_hiy_q;
  cps_pkg::scale_t           s_q;

  logic [NW-1:0] prodx_d, prody_d;

  always_comb begin
    prodx_d = ({{(NW-MW-HW){1'b0}}, p_hix_q} << LW) + {{(NW-MW-LW){1'b0}}, p_lox_q};
    prody_d = ({{(NW-MW-HW){1'b0}}, p_hiy_q} << LW) + {{(NW-MW-LW){1'b0}}, p_loy_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_zero_q <= data_i.zero;
      p_sgnx_q <= data_i.sgnx;
      p_sgny_q <= data_i.sgny;
      p_sx_q   <= data_i.sx;
      p_sy_q   <= data_i.sy;
      p_den_q  <= data_i.den;
      p_lox_q  <= data_i.mx * data_i.numc[LW-1:0];
      p_loy_q  <= data_i.my * data_i.numc[LW-1:0];
      p_hix_q  <= data_i.mx * data_i.numc[DW-1:LW];
      p_hiy_q  <= data_i.my * data_i.numc[DW-1:LW];

      s_q.zero <= p_zero_q;
      s_q.sgnx <= p_sgnx_q;
      s_q.sgny <= p_sgny_q;
      s_q.sx   <= p_sx_q;
      s_q.sy   <= p_sy_q;
      // 2*m*num + den gives round half away from zero after dividing by 2*den
      s_q.n2x  <= (prodx_d << 1) + {{(NW-DW){1'b0}}, p_den_q};
      s_q.n2y  <= (prody_d << 1) + {{(NW-DW){1'b0}}, p_den_q};
      s_q.d2   <= {p_den_q, 1'b0};
    end
  end

  assign valid_o = valid_q[1];
  assign data_o  = s_q;

  `CPS_ASSERT_IMP(a_quot_fits, valid_q[1] && !s_q.zero, s_q.n2x[NW-1:cps_pkg::QW] < {1'b0, s_q.d2}, "quotient overflow")

endmodule

// ----- src/cps_div.sv -----
// ----------------------------------------------------------------------------
// cps_div
// Restoring divider for both axes, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_macros.svh"

module cps_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  cps_pkg::scale_t data_i,
  output logic            valid_o,
  output cps_pkg::div_t   data_o
);

  localparam int unsigned NS = cps_pkg::DivStages;
  localparam int unsigned RW = cps_pkg::RemW;
  localparam int unsigned QW = cps_pkg::QW;
  localparam int unsigned DW = cps_pkg::D2W;

  logic [NS-1:0]   valid_q;
  cps_pkg::div_t   st_q [NS];
  cps_pkg::div_t   st_in [NS];
  cps_pkg::div_t   st_d [NS];

  logic [RW:0] tx_d [NS];
  logic [RW:0] ty_d [NS];
  logic [RW:0] subx_d [NS];
  logic [RW:0] suby_d [NS];
  logic        gex_d [NS];
  logic        gey_d [NS];

  always_comb begin
    st_in[0]      = '0;
    st_in[0].zero = data_i.zero;
    st_in[0].sx   = data_i.sx;
    st_in[0].sy   = data_i.sy;
    st_in[0].sgnx = data_i.sgnx;
    st_in[0].sgny = data_i.sgny;
    st_in[0].d2   = data_i.d2;
    st_in[0].remx = data_i.n2x[cps_pkg::N2W-1:QW];
    st_in[0].remy = data_i.n2y[cps_pkg::N2W-1:QW];
    st_in[0].lowx = data_i.n2x[QW-1:0];
    st_in[0].lowy = data_i.n2y[QW-1:0];
    for (int k = 1; k < NS; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      tx_d[k]   = {st_in[k].remx, st_in[k].lowx[QW-1]};
      ty_d[k]   = {st_in[k].remy, st_in[k].lowy[QW-1]};
      subx_d[k] = tx_d[k] - {{(RW+1-DW){1'b0}}, st_in[k].d2};
      suby_d[k] = ty_d[k] - {{(RW+1-DW){1'b0}}, st_in[k].d2};
      gex_d[k]  = tx_d[k] >= {{(RW+1-DW){1'b0}}, st_in[k].d2};
      gey_d[k]  = ty_d[k] >= {{(RW+1-DW){1'b0}}, st_in[k].d2};
      st_d[k]      = st_in[k];
      st_d[k].remx = gex_d[k] ? subx_d[k][RW-1:0] : tx_d[k][RW-1:0];
      st_d[k].remy = gey_d[k] ? suby_d[k][RW-1:0] : ty_d[k][RW-1:0];
      st_d[k].lowx = st_in[k].lowx << 1;
      st_d[k].lowy = st_in[k].lowy << 1;
      st_d[k].qx   = {st_in[k].qx[QW-2:0], gex_d[k]};
      st_d[k].qy   = {st_in[k].qy[QW-2:0], gey_d[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = valid_q[NS-1];
  assign data_o  = st_q[NS-1];

  `CPS_ASSERT_IMP(a_rem_bound, valid_q[NS-1] && !st_q[NS-1].zero, st_q[NS-1].remx < {{(RW-DW){1'b0}}, st_q[NS-1].d2}, "remainder not below divisor")

endmodule

// ----- src/closest_point_on_segment_core.sv -----
// ----------------------------------------------------------------------------
// closest_point_on_segment_core
// Closest point on a 2D segment to a query point, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_i) takes one word per
//   cycle while in_ready_o is high, holding segment start, segment end
//   and query point. The output channel (out_valid_o / out_ready_i /
//   out_o) returns one word per input word, in order, holding the nearest
//   point on the segment. Throughput is one word per cycle unless the
//   output stalls. Four stages form the squared length and clamped dot
//   product, two scale it by each axis length, 32 stages run the restoring
//   divider one quotient bit each, and one stage adds the offset to start.
//   A zero-length segment returns its start point.
//   Reset clears every stage valid bit; no word is in flight afterward.
//   When the receiver holds out_ready_i low with a word waiting, the whole
//   pipeline holds and in_ready_o drops; nothing is lost or repeated, and
//   the pipeline resumes on the cycle out_ready_i returns.
// ----------------------------------------------------------------------------
`include "closest_point_on_segment_core_macros.svh"

module closest_point_on_segment_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cps_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cps_pkg::out_t out_o
);

  localparam int unsigned CW = cps_pkg::CoordW;

  logic            en;
  logic            front_valid, scale_valid, div_valid;
  cps_pkg::front_t front_data;
  cps_pkg::scale_t scale_data;
  cps_pkg::div_t   div_data;

  logic          out_valid_q;
  cps_pkg::out_t out_q;
  cps_pkg::out_t out_d;

  // advance everything unless a finished word is stuck at the output
  assign en = !out_valid_q || out_ready_i;

  cps_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_i),
    .valid_o (front_valid),
    .data_o  (front_data)
  );

  cps_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (scale_valid),
    .data_o  (scale_data)
  );

  cps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (scale_valid),
    .data_i  (scale_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  always_comb begin
    if (div_data.zero) begin
      out_d.closest_x = div_data.sx;
      out_d.closest_y = div_data.sy;
    end else begin
      out_d.closest_x = div_data.sgnx ? CW'(div_data.sx - div_data.qx)
                                      : CW'(div_data.sx + div_data.qx);
      out_d.closest_y = div_data.sgny ? CW'(div_data.sy - div_data.qy)
                                      : CW'(div_data.sy + div_data.qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CPS_ASSERT(a_out_source, $rose(out_valid_o) |-> $past(div_valid), "output word without source")

endmodule
